// ===== src/bstk_pkg.sv =====
// Shared types, constants and helper functions of the bounded sorted top-k list.
// Used by the RAM, the controller, the top level and the checker; depends on nothing.
`timescale 1ns / 1ps

package bstk_pkg;

   // Default sizing of the list storage.
   localparam int DEF_LIST_DEPTH = 16;
   localparam int DEF_TAG_BITS   = 16;

   // Fixed field widths.
   localparam int SCORE_W = 32;
   localparam int COUNT_W = 5;
   localparam int RANK_W  = 4;

   // Limit register value after reset.
   localparam logic [COUNT_W-1:0] MAX_KEPT_RESET = 5'd16;

   // Command codes.
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_CLEAR  = 1'b1;

   // One result item.
   typedef struct packed {
      logic               accepted;
      logic [RANK_W-1:0]  rank;
      logic [COUNT_W-1:0] kept_count;
      logic               evicted;
   } rsp_type;

   // Limit update handed from the register file to the controller.
   typedef struct packed {
      logic               wr;
      logic [COUNT_W-1:0] lim;
   } cfg_type;

   // Address bits needed for a memory of the given depth.
   function automatic int addr_bits(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

   // Effective entry limit: the register clamped to one up to the list depth.
   function automatic logic [COUNT_W-1:0] limit_of(input logic [COUNT_W-1:0] mk,
                                                   input int depth);
      if (mk == '0) begin
         return {{(COUNT_W-1){1'b0}}, 1'b1};
      end else if (int'(mk) > depth) begin
         return COUNT_W'(depth);
      end
      return mk;
   endfunction

endpackage

// ===== src/bstk_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// Uses bstk_pkg for the address width helper.
`timescale 1ns / 1ps

module bstk_ram
   import bstk_pkg::*;
#(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16,
   localparam int AddrW = addr_bits(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AddrW-1:0] waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AddrW-1:0] raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/bstk_ctrl.sv =====
// Insertion sequencer: walks the list from its worst entry upward, shifting entries
// down one place in the RAM until the insertion point is found. Uses bstk_pkg.
`timescale 1ns / 1ps

module bstk_ctrl
   import bstk_pkg::*;
#(
   parameter int LIST_DEPTH = DEF_LIST_DEPTH,
   parameter int TAG_BITS   = DEF_TAG_BITS,
   localparam int AddrW  = addr_bits(LIST_DEPTH),
   localparam int EntryW = SCORE_W + TAG_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                req_cmd,
   input  logic [SCORE_W-1:0]  req_score,
   input  logic [TAG_BITS-1:0] req_entry_tag,
   input  logic [COUNT_W-1:0]  lim,
   input  cfg_type             cfg,
   output logic                busy,
   output logic                rsp_valid,
   output rsp_type             rsp,
   output logic                ram_we,
   output logic [AddrW-1:0]    ram_waddr,
   output logic [EntryW-1:0]   ram_wdata,
   output logic                ram_re,
   output logic [AddrW-1:0]    ram_raddr,
   input  logic [EntryW-1:0]   ram_rdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINAL
   } state_type;

   state_type             state_ff, state_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [COUNT_W-1:0]    idx_ff, idx_in;
   logic [SCORE_W-1:0]    score_ff, score_in;
   logic [TAG_BITS-1:0]   tag_ff, tag_in;
   logic                  full_ff, full_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic [SCORE_W-1:0]    rd_score;
   logic                  rd_less;
   logic [COUNT_W-1:0]    idx_next;
   logic [COUNT_W-1:0]    count_dec;
   logic [COUNT_W-1:0]    count_inc;

   // Zero-extend or truncate a list index to a RAM address.
   function automatic logic [AddrW-1:0] to_addr(input logic [COUNT_W-1:0] v);
      logic [AddrW+COUNT_W-1:0] w;
      w = {{AddrW{1'b0}}, v};
      return w[AddrW-1:0];
   endfunction

   assign rd_score  = ram_rdata[EntryW-1 -: SCORE_W];
   assign rd_less   = rd_score < score_ff;
   assign idx_next  = idx_ff + COUNT_W'(1);
   assign count_dec = count_ff - COUNT_W'(1);
   assign count_inc = count_ff + COUNT_W'(1);

   // Next-state logic and RAM requests.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      score_in     = score_ff;
      tag_in       = tag_ff;
      full_in      = full_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_waddr    = '0;
      ram_wdata    = {score_ff, tag_ff};
      ram_re       = 1'b0;
      ram_raddr    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_cmd == CMD_CLEAR) begin
                  count_in     = '0;
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{accepted: 1'b0, rank: '0, kept_count: '0, evicted: 1'b0};
               end else if (count_ff == '0) begin
                  // Empty list: the item goes straight to the head.
                  ram_we       = 1'b1;
                  ram_waddr    = '0;
                  ram_wdata    = {req_score, req_entry_tag};
                  count_in     = COUNT_W'(1);
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{accepted: 1'b1, rank: '0, kept_count: COUNT_W'(1),
                                   evicted: 1'b0};
               end else begin
                  // Start at the worst kept entry.
                  ram_re    = 1'b1;
                  ram_raddr = to_addr(count_dec);
                  idx_in    = count_dec;
                  score_in  = req_score;
                  tag_in    = req_entry_tag;
                  full_in   = count_ff >= lim;
                  state_in  = ST_SCAN;
               end
            end else if (cfg.wr && count_ff > cfg.lim) begin
               // A lowered limit drops the worst entries.
               count_in = cfg.lim;
            end
         end

         ST_SCAN: begin
            if (rd_less) begin
               // The read entry moves one place down unless it falls off the end.
               if (idx_next < lim) begin
                  ram_we    = 1'b1;
                  ram_waddr = to_addr(idx_next);
                  ram_wdata = ram_rdata;
               end
               if (idx_ff == '0) begin
                  state_in = ST_FINAL;
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = to_addr(idx_ff - COUNT_W'(1));
                  idx_in    = idx_ff - COUNT_W'(1);
               end
            end else if (full_ff && idx_next == count_ff) begin
               // Full list and no kept score is beaten.
               rsp_valid_in = 1'b1;
               rsp_in       = '{accepted: 1'b0, rank: '0, kept_count: count_ff,
                                evicted: 1'b0};
               state_in     = ST_IDLE;
            end else begin
               ram_we       = 1'b1;
               ram_waddr    = to_addr(idx_next);
               count_in     = full_ff ? count_ff : count_inc;
               rsp_valid_in = 1'b1;
               rsp_in       = '{accepted: 1'b1, rank: idx_next[RANK_W-1:0],
                                kept_count: full_ff ? count_ff : count_inc,
                                evicted: full_ff};
               state_in     = ST_IDLE;
            end
         end

         ST_FINAL: begin
            // Every kept entry was worse: the item becomes the new head.
            ram_we       = 1'b1;
            ram_waddr    = '0;
            count_in     = full_ff ? count_ff : count_inc;
            rsp_valid_in = 1'b1;
            rsp_in       = '{accepted: 1'b1, rank: '0,
                             kept_count: full_ff ? count_ff : count_inc, evicted: full_ff};
            state_in     = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff   <= idx_in;
      score_ff <= score_in;
      tag_ff   <= tag_in;
      full_ff  <= full_in;
      rsp_ff   <= rsp_in;
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ===== src/bounded_sorted_topk_insert.sv =====
// Top level of the bounded sorted top-k list: limit register, sequencer and entry RAM.
// Depends on bstk_pkg, bstk_ram and bstk_ctrl.
// A clear or an insert into an empty list strobes its result in the cycle after start.
// An insert into a non-empty list holds busy while it reads entries worst to best, plus a head
// write if it lands at the head (one-read, one-write RAM); its result strobes as busy falls.
// The receiver cannot stall. Synchronous reset empties the list and sets the limit to 16.
`timescale 1ns / 1ps

module bounded_sorted_topk_insert
   import bstk_pkg::*;
#(
   parameter int LIST_DEPTH = DEF_LIST_DEPTH,
   parameter int TAG_BITS   = DEF_TAG_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_cmd,
   input  logic [SCORE_W-1:0]  req_score,
   input  logic [TAG_BITS-1:0] req_entry_tag,
   output logic                rsp_valid,
   output logic                rsp_accepted,
   output logic [RANK_W-1:0]   rsp_rank,
   output logic [COUNT_W-1:0]  rsp_kept_count,
   output logic                rsp_evicted,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [COUNT_W-1:0]  csr_data
);

   localparam int AddrW  = addr_bits(LIST_DEPTH);
   localparam int EntryW = SCORE_W + TAG_BITS;

   logic [COUNT_W-1:0] lim_ff, lim_in;
   cfg_type            cfg;
   rsp_type            rsp;
   logic               ram_we;
   logic [AddrW-1:0]   ram_waddr;
   logic [EntryW-1:0]  ram_wdata;
   logic               ram_re;
   logic [AddrW-1:0]   ram_raddr;
   logic [EntryW-1:0]  ram_rdata;

   // Limit register holds the clamped limit. A write waits while an item is offered or busy.
   assign csr_ready = ~busy & ~start;
   assign cfg.wr    = csr_valid & csr_ready;
   assign cfg.lim   = limit_of(csr_data, LIST_DEPTH);
   assign lim_in    = cfg.wr ? cfg.lim : lim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff <= limit_of(MAX_KEPT_RESET, LIST_DEPTH);
      end else begin
         lim_ff <= lim_in;
      end
   end

   bstk_ctrl #(
      .LIST_DEPTH (LIST_DEPTH),
      .TAG_BITS   (TAG_BITS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_cmd       (req_cmd),
      .req_score     (req_score),
      .req_entry_tag (req_entry_tag),
      .lim           (lim_ff),
      .cfg           (cfg),
      .busy          (busy),
      .rsp_valid     (rsp_valid),
      .rsp           (rsp),
      .ram_we        (ram_we),
      .ram_waddr     (ram_waddr),
      .ram_wdata     (ram_wdata),
      .ram_re        (ram_re),
      .ram_raddr     (ram_raddr),
      .ram_rdata     (ram_rdata)
   );

   bstk_ram #(
      .WIDTH (EntryW),
      .DEPTH (LIST_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rsp_accepted   = rsp.accepted;
   assign rsp_rank       = rsp.rank;
   assign rsp_kept_count = rsp.kept_count;
   assign rsp_evicted    = rsp.evicted;

endmodule

// ===== src/bstk_checker.sv =====
// Port-level checks of the bounded sorted top-k list, bound to the top level.
// Depends on bstk_pkg and bounded_sorted_topk_insert.
`timescale 1ns / 1ps

module bstk_checker
   import bstk_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               req_cmd,
   input logic               rsp_valid,
   input logic               rsp_accepted,
   input logic [RANK_W-1:0]  rsp_rank,
   input logic [COUNT_W-1:0] rsp_kept_count,
   input logic               rsp_evicted
);

   // A clear answers in the next cycle with an empty list.
   a_clear_next: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_cmd == CMD_CLEAR |=> rsp_valid && rsp_kept_count == '0)
      else $error("clear did not answer with an empty list");

   // An eviction only comes with an accepted item.
   a_evict_acc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted |-> rsp_accepted)
      else $error("eviction without acceptance");

   // A rejected item reports rank zero.
   a_reject_rank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_accepted |-> rsp_rank == '0)
      else $error("rejected item with nonzero rank");

   // An accepted item lies inside the list.
   a_rank_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted && rsp_kept_count <= COUNT_W'(16)
      |-> COUNT_W'(rsp_rank) < rsp_kept_count)
      else $error("rank beyond kept count");

endmodule

bind bounded_sorted_topk_insert bstk_checker u_bstk_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_cmd        (req_cmd),
   .rsp_valid      (rsp_valid),
   .rsp_accepted   (rsp_accepted),
   .rsp_rank       (rsp_rank),
   .rsp_kept_count (rsp_kept_count),
   .rsp_evicted    (rsp_evicted)
);

// ===== tb/bounded_sorted_topk_insert_tb.sv =====
// Self-checking testbench of the bounded sorted top-k list: a directed table, then random
// inserts, clears and limit writes; results are checked against a predictor or the table.
// Depends on bstk_pkg and bounded_sorted_topk_insert.
`timescale 1ns / 1ps

module bounded_sorted_topk_insert_tb;
   import bstk_pkg::*;

   localparam int DEPTH       = DEF_LIST_DEPTH;
   localparam int TAG_W       = DEF_TAG_BITS;
   localparam int STALL_LIMIT = 2000;

   typedef enum logic {ROW_ITEM, ROW_LIMIT} row_kind_type;

   // One row of the directed table: an item or a limit write, with an optional
   // hand-written outcome.
   typedef struct packed {
      row_kind_type       kind;
      logic               cmd;
      logic [SCORE_W-1:0] score;
      logic [TAG_W-1:0]   tag;
      logic [COUNT_W-1:0] limit;
      logic               fixed;
      rsp_type            outcome;
   } dir_row_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic                req_cmd;
   logic [SCORE_W-1:0]  req_score;
   logic [TAG_W-1:0]    req_entry_tag;
   logic                rsp_valid;
   logic                rsp_accepted;
   logic [RANK_W-1:0]   rsp_rank;
   logic [COUNT_W-1:0]  rsp_kept_count;
   logic                rsp_evicted;
   logic                csr_valid;
   logic                csr_ready;
   logic [COUNT_W-1:0]  csr_data;

   // Predictor state: the kept list and the limit register.
   logic [SCORE_W-1:0]  list_score [DEPTH];
   logic [TAG_W-1:0]    list_tag [DEPTH];
   int                  list_count;
   logic [COUNT_W-1:0]  limit_reg;

   rsp_type             placements_due [$];
   dir_row_type         dir_rows [$];
   int                  sender_idle_pct;
   int                  error_count;
   int                  result_index;
   int                  stall_cycles;

   bounded_sorted_topk_insert dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_score      (req_score),
      .req_entry_tag  (req_entry_tag),
      .rsp_valid      (rsp_valid),
      .rsp_accepted   (rsp_accepted),
      .rsp_rank       (rsp_rank),
      .rsp_kept_count (rsp_kept_count),
      .rsp_evicted    (rsp_evicted),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_error(input string what);
      $display("ERROR at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // The register clamped to one up to the list depth.
   function automatic int active_limit();
      if (limit_reg == 0) begin
         return 1;
      end else if (int'(limit_reg) > DEPTH) begin
         return DEPTH;
      end
      return int'(limit_reg);
   endfunction

   // Applies one item to the predicted list and returns the outcome it gives.
   task automatic place_candidate(input logic cmd, input logic [SCORE_W-1:0] score,
                                  input logic [TAG_W-1:0] tag, output rsp_type outcome);
      int  lim;
      int  pos;
      int  last;
      int  i;
      bit  full;
      lim = active_limit();
      outcome = '0;
      if (list_count > lim) list_count = lim;
      if (cmd == CMD_CLEAR) begin
         list_count = 0;
      end else begin
         pos = 0;
         while (pos < list_count && list_score[pos] >= score) pos++;
         full = (list_count >= lim);
         if (!full || pos < list_count) begin
            outcome.accepted = 1'b1;
            outcome.evicted  = full;
            outcome.rank     = RANK_W'(pos);
            last = full ? list_count - 1 : list_count;
            for (i = last; i > pos; i--) begin
               list_score[i] = list_score[i-1];
               list_tag[i]   = list_tag[i-1];
            end
            list_score[pos] = score;
            list_tag[pos]   = tag;
            if (!full) list_count++;
         end
      end
      outcome.kept_count = COUNT_W'(list_count);
   endtask

   // Stops sending and waits until every expected result has come back.
   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (placements_due.size() != 0) @(negedge clock);
   endtask

   // Writes the limit register while the list is idle and updates the prediction.
   task automatic write_limit(input logic [COUNT_W-1:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      limit_reg = value;
      if (list_count > active_limit()) list_count = active_limit();
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Offers one item after a random gap and records its outcome once accepted.
   task automatic send_item(input logic cmd, input logic [SCORE_W-1:0] score,
                            input logic [TAG_W-1:0] tag, input bit use_fixed,
                            input rsp_type fixed_outcome);
      rsp_type predicted;
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start         <= 1'b1;
      req_cmd       <= cmd;
      req_score     <= score;
      req_entry_tag <= tag;
      do @(posedge clock); while (busy);
      place_candidate(cmd, score, tag, predicted);
      placements_due.push_back(use_fixed ? fixed_outcome : predicted);
   endtask

   task automatic add_row(input row_kind_type kind, input logic cmd,
                          input logic [SCORE_W-1:0] score, input logic [TAG_W-1:0] tag,
                          input logic [COUNT_W-1:0] limit, input logic fixed,
                          input logic acc, input logic [RANK_W-1:0] rank,
                          input logic [COUNT_W-1:0] count, input logic ev);
      dir_row_type row;
      row.kind    = kind;
      row.cmd     = cmd;
      row.score   = score;
      row.tag     = tag;
      row.limit   = limit;
      row.fixed   = fixed;
      row.outcome = {acc, rank, count, ev};
      dir_rows.push_back(row);
   endtask

   // Result checker: every strobe is matched against the oldest expected outcome.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (placements_due.size() == 0) begin
            report_error($sformatf("result %0d arrived with none expected", result_index));
         end else begin
            want = placements_due.pop_front();
            if (rsp_accepted !== want.accepted)
               report_error($sformatf("result %0d accepted: got %b, expected %b",
                                      result_index, rsp_accepted, want.accepted));
            if (rsp_rank !== want.rank)
               report_error($sformatf("result %0d rank: got %0d, expected %0d",
                                      result_index, rsp_rank, want.rank));
            if (rsp_kept_count !== want.kept_count)
               report_error($sformatf("result %0d kept_count: got %0d, expected %0d",
                                      result_index, rsp_kept_count, want.kept_count));
            if (rsp_evicted !== want.evicted)
               report_error($sformatf("result %0d evicted: got %b, expected %b",
                                      result_index, rsp_evicted, want.evicted));
         end
         result_index++;
      end
   end

   // Watchdog: ends the run when nothing has moved for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles = stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Main sequence: reset, directed table, random phases, final check.
   initial begin
      int                  phase;
      int                  blk;
      int                  n;
      logic                cmd;
      logic [SCORE_W-1:0]  score;
      logic [TAG_W-1:0]    tag;
      logic [COUNT_W-1:0]  lim_val;
      reset           = 1'b1;
      start           = 1'b0;
      req_cmd         = CMD_INSERT;
      req_score       = '0;
      req_entry_tag   = '0;
      csr_valid       = 1'b0;
      csr_data        = '0;
      list_count      = 0;
      limit_reg       = MAX_KEPT_RESET;
      sender_idle_pct = 0;
      error_count     = 0;
      result_index    = 0;
      stall_cycles    = 0;
      for (n = 0; n < DEPTH; n++) begin
         list_score[n] = '0;
         list_tag[n]   = '0;
      end

      // Directed table. Hand-written outcomes only where they are obvious.
      add_row(ROW_ITEM,  CMD_CLEAR,  32'h0000_0000, 16'h0000, 5'd0,  1, 0, 4'd0, 5'd0, 0);
      add_row(ROW_ITEM,  CMD_INSERT, 32'h0000_0000, 16'h0000, 5'd0,  1, 1, 4'd0, 5'd1, 0);
      add_row(ROW_ITEM,  CMD_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 5'd0,  0, 0, 4'd0, 5'd0, 0);
      add_row(ROW_ITEM,  CMD_INSERT, 32'h8000_0000, 16'hA5A5, 5'd0,  0, 0, 4'd0, 5'd0, 0);
      // An equal score goes in after the entry already kept.
      add_row(ROW_ITEM,  CMD_INSERT, 32'h8000_0000, 16'h5A5A, 5'd0,  0, 0, 4'd0, 5'd0, 0);
      // A clear ignores its score and tag.
      add_row(ROW_ITEM,  CMD_CLEAR,  32'hDEAD_BEEF, 16'hFFFF, 5'd0,  1, 0, 4'd0, 5'd0, 0);
      // A limit of one: equal or lower scores are rejected, a better one evicts.
      add_row(ROW_LIMIT, CMD_INSERT, 32'h0,         16'h0,    5'd1,  0, 0, 4'd0, 5'd0, 0);
      add_row(ROW_ITEM,  CMD_INSERT, 32'h0001_0000, 16'h0001, 5'd0,  1, 1, 4'd0, 5'd1, 0);
      add_row(ROW_ITEM,  CMD_INSERT, 32'h0001_0000, 16'h0002, 5'd0,  1, 0, 4'd0, 5'd1, 0);
      add_row(ROW_ITEM,  CMD_INSERT, 32'h0000_FFFF, 16'h0003, 5'd0,  1, 0, 4'd0, 5'd1, 0);
      add_row(ROW_ITEM,  CMD_INSERT, 32'h0001_0001, 16'h0004, 5'd0,  1, 1, 4'd0, 5'd1, 1);
      // A limit of zero behaves as a limit of one.
      add_row(ROW_LIMIT, CMD_INSERT, 32'h0,         16'h0,    5'd0,  0, 0, 4'd0, 5'd0, 0);
      add_row(ROW_ITEM,  CMD_INSERT, 32'hFFFF_FFFF, 16'h8000, 5'd0,  1, 1, 4'd0, 5'd1, 1);
      add_row(ROW_ITEM,  CMD_INSERT, 32'h0000_0000, 16'h7FFF, 5'd0,  1, 0, 4'd0, 5'd1, 0);
      // A limit of two, filled, then a tie with the worst entry.
      add_row(ROW_LIMIT, CMD_INSERT, 32'h0,         16'h0,    5'd2,  0, 0, 4'd0, 5'd0, 0);
      add_row(ROW_ITEM,  CMD_INSERT, 32'h0000_0010, 16'h0010, 5'd0,  0, 0, 4'd0, 5'd0, 0);
      add_row(ROW_ITEM,  CMD_INSERT, 32'h0000_0020, 16'h0020, 5'd0,  0, 0, 4'd0, 5'd0, 0);
      add_row(ROW_ITEM,  CMD_INSERT, 32'h0000_0020, 16'h0021, 5'd0,  0, 0, 4'd0, 5'd0, 0);
      // Lowering the limit below the count drops the worst entries.
      add_row(ROW_LIMIT, CMD_INSERT, 32'h0,         16'h0,    5'd1,  0, 0, 4'd0, 5'd0, 0);
      add_row(ROW_ITEM,  CMD_INSERT, 32'h0000_0005, 16'h0005, 5'd0,  1, 0, 4'd0, 5'd1, 0);
      // A limit above the depth saturates.
      add_row(ROW_LIMIT, CMD_INSERT, 32'h0,         16'h0,    5'd31, 0, 0, 4'd0, 5'd0, 0);
      add_row(ROW_ITEM,  CMD_INSERT, 32'h7FFF_FFFF, 16'h8000, 5'd0,  0, 0, 4'd0, 5'd0, 0);
      add_row(ROW_ITEM,  CMD_INSERT, 32'hFFFF_FFFF, 16'h7FFF, 5'd0,  0, 0, 4'd0, 5'd0, 0);
      add_row(ROW_ITEM,  CMD_INSERT, 32'h0000_0000, 16'h0000, 5'd0,  0, 0, 4'd0, 5'd0, 0);

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[n]) begin
         if (dir_rows[n].kind == ROW_LIMIT) begin
            write_limit(dir_rows[n].limit);
         end else begin
            send_item(dir_rows[n].cmd, dir_rows[n].score, dir_rows[n].tag,
                      dir_rows[n].fixed, dir_rows[n].outcome);
         end
      end

      // Random part: three idle profiles, each split into blocks under one limit.
      for (phase = 0; phase < 3; phase++) begin
         sender_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 64 : 0;
         for (blk = 0; blk < 7; blk++) begin
            case ($urandom_range(5))
               0:       lim_val = 5'd0;
               1:       lim_val = 5'd31;
               2:       lim_val = 5'd16;
               3:       lim_val = COUNT_W'($urandom_range(4, 1));
               default: lim_val = COUNT_W'($urandom_range(31));
            endcase
            write_limit(lim_val);
            for (n = 0; n < 43; n++) begin
               cmd = ($urandom_range(29) == 0) ? CMD_CLEAR : CMD_INSERT;
               // Mix narrow and full-range scores so ties and rejections occur often.
               case ($urandom_range(7))
                  0, 1:    score = SCORE_W'($urandom_range(15));
                  2:       score = $urandom_range(1) ? '1 : '0;
                  3, 4:    score = (list_count > 0) ?
                                   list_score[$urandom_range(list_count - 1)] : $urandom();
                  default: score = $urandom();
               endcase
               tag = TAG_W'($urandom());
               send_item(cmd, score, tag, 1'b0, '0);
               if ($urandom_range(99) == 0) drain_results();
            end
         end
      end

      drain_results();
      repeat (25) @(negedge clock);
      if (placements_due.size() != 0)
         report_error($sformatf("%0d results never arrived", placements_due.size()));
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
